FILE: rtl/core/dkd_pkg.sv
`default_nettype none
package dkd_pkg;

  localparam int unsigned NUM_KEYS      = 2;
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned TIME_W        = 16;
  localparam int unsigned EVENT_W       = 3;
  localparam int unsigned IN_TDATA_W    = 40;
  localparam int unsigned OUT_TDATA_W   = 8;
  localparam int unsigned KEY_BIT_BASE  = 32;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET   = 16'd30;
  localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 16'd500;

  typedef enum logic [0:0] {
    REG_DEBOUNCE_TIME   = 1'b0,
    REG_LONG_PRESS_TIME = 1'b1
  } reg_index_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE       = 3'd0,
    EV_KEY0_SHORT = 3'd1,
    EV_KEY1_SHORT = 3'd2,
    EV_KEY0_LONG  = 3'd3,
    EV_KEY1_LONG  = 3'd4
  } event_code_t;

  typedef struct packed {
    logic is_short;
    logic is_long;
  } key_event_t;

endpackage
`default_nettype wire

FILE: rtl/core/dual_key_debounce_long_press_unit.sv
// A scan's event code is registered at the output, or in the skid entry on a stall.
// Throughput: one scan per cycle while the skid entry is empty; lanes update on accept.
// A two-entry output buffer takes one more scan into the skid entry on an output stall.
// Reset (rst, synchronous): keys released, stamps and flags cleared,
// debounce time 30 and long press time 500.
`default_nettype none
module dual_key_debounce_long_press_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // now_time[31:0], key0_level[32], key1_level[33], zero fill
  input  wire logic [dkd_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // event_code[2:0], zero fill
  output logic [dkd_pkg::OUT_TDATA_W-1:0]         m_tdata,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [dkd_pkg::TIME_W-1:0]         cfg_data
);
  import dkd_pkg::*;

  logic [TIME_W-1:0]                debounce_time;
  logic [TIME_W-1:0]                long_press_time;
  logic                             accept;
  key_event_t [NUM_KEYS-1:0]        key_events;
  event_code_t                      event_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_DEBOUNCE_TIME:   debounce_time   <= cfg_data;
        REG_LONG_PRESS_TIME: long_press_time <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    dkd_lane u_lane (
      .clk             (clk),
      .rst             (rst),
      .accept          (accept),
      .now_time        (s_tdata[STAMP_W-1:0]),
      .key_level       (s_tdata[KEY_BIT_BASE+k]),
      .debounce_time   (debounce_time),
      .long_press_time (long_press_time),
      .key_event       (key_events[k])
    );
  end

  dkd_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .key_events (key_events),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .event_code (event_code)
  );

  assign m_tdata = {{(OUT_TDATA_W-EVENT_W){1'b0}}, event_code};

endmodule
`default_nettype wire

FILE: rtl/core/dkd_lane.sv
`default_nettype none
module dkd_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [dkd_pkg::STAMP_W-1:0]   now_time,
  input  wire logic                          key_level,
  input  wire logic [dkd_pkg::TIME_W-1:0]    debounce_time,
  input  wire logic [dkd_pkg::TIME_W-1:0]    long_press_time,
  output dkd_pkg::key_event_t                key_event
);
  import dkd_pkg::*;

  logic               raw_last;
  logic               level_stable;
  logic [STAMP_W-1:0] change_stamp;
  logic [STAMP_W-1:0] press_stamp;
  logic               held_flag;
  logic               long_reported;

  logic               level_stable_next;
  logic [STAMP_W-1:0] change_stamp_next;
  logic [STAMP_W-1:0] press_stamp_next;
  logic               held_flag_next;
  logic               long_reported_next;

  logic               deb_ok;
  logic               settle;
  logic               press;
  logic               release_ev;
  logic               long_hit;

  always_comb begin
    change_stamp_next  = (key_level != raw_last) ? now_time : change_stamp;
    deb_ok             = (now_time - change_stamp_next) >=
                         {{(STAMP_W-TIME_W){1'b0}}, debounce_time};
    settle             = deb_ok && (level_stable != key_level);
    press              = settle && !key_level;
    release_ev         = settle && key_level;
    level_stable_next  = settle ? key_level : level_stable;
    held_flag_next     = press ? 1'b1 : (release_ev ? 1'b0 : held_flag);
    press_stamp_next   = press ? now_time : press_stamp;
    long_hit           = held_flag_next && !(press ? 1'b0 : long_reported) &&
                         ((now_time - press_stamp_next) >=
                          {{(STAMP_W-TIME_W){1'b0}}, long_press_time});
    long_reported_next = long_hit ? 1'b1 : (press ? 1'b0 : long_reported);
    key_event.is_short = release_ev && !long_reported;
    key_event.is_long  = long_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last      <= 1'b1;
      level_stable  <= 1'b1;
      change_stamp  <= '0;
      press_stamp   <= '0;
      held_flag     <= 1'b0;
      long_reported <= 1'b0;
    end else if (accept) begin
      raw_last      <= key_level;
      level_stable  <= level_stable_next;
      change_stamp  <= change_stamp_next;
      press_stamp   <= press_stamp_next;
      held_flag     <= held_flag_next;
      long_reported <= long_reported_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dkd_merge.sv
`default_nettype none
module dkd_merge (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                accept,
  input  wire dkd_pkg::key_event_t [dkd_pkg::NUM_KEYS-1:0] key_events,
  output logic                                     in_ready,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output dkd_pkg::event_code_t                     event_code
);
  import dkd_pkg::*;

  event_code_t merged;
  event_code_t skid_code;
  logic        skid_valid;

  always_comb begin
    priority if (key_events[0].is_long)  merged = EV_KEY0_LONG;
    else if     (key_events[1].is_long)  merged = EV_KEY1_LONG;
    else if     (key_events[0].is_short) merged = EV_KEY0_SHORT;
    else if     (key_events[1].is_short) merged = EV_KEY1_SHORT;
    else                                 merged = EV_NONE;
  end

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      event_code <= skid_valid ? skid_code : merged;
    end else if (accept) begin
      skid_code <= merged;
    end
  end

endmodule
`default_nettype wire

FILE: tb/dual_key_debounce_long_press_unit_tb.sv
`default_nettype none

class key_event_board;
  logic [15:0] debounce_ms;
  logic [15:0] long_ms;
  logic        raw_last[2];
  logic        level_stable[2];
  logic [31:0] change_stamp[2];
  logic [31:0] press_stamp[2];
  logic        held[2];
  logic        long_done[2];
  dkd_pkg::event_code_t expected_events[$];
  int          mismatches;
  int          events_checked;
  int          event_tally[5];

  function new();
    mismatches = 0;
    events_checked = 0;
    foreach (event_tally[i]) event_tally[i] = 0;
    clear_keys();
  endfunction

  function void clear_keys();
    debounce_ms = dkd_pkg::DEBOUNCE_RESET;
    long_ms     = dkd_pkg::LONG_PRESS_RESET;
    for (int k = 0; k < 2; k++) begin
      raw_last[k]     = 1'b1;
      level_stable[k] = 1'b1;
      change_stamp[k] = '0;
      press_stamp[k]  = '0;
      held[k]         = 1'b0;
      long_done[k]    = 1'b0;
    end
  endfunction

  function void set_reg(dkd_pkg::reg_index_t idx, logic [15:0] value);
    case (idx)
      dkd_pkg::REG_DEBOUNCE_TIME:   debounce_ms = value;
      dkd_pkg::REG_LONG_PRESS_TIME: long_ms = value;
      default: ;
    endcase
  endfunction

  function void step_key(int k, logic [31:0] now, logic raw,
                         output bit is_short, output bit is_long);
    logic [31:0] since;
    is_short = 1'b0;
    is_long  = 1'b0;
    if (raw != raw_last[k]) begin
      raw_last[k]     = raw;
      change_stamp[k] = now;
    end
    since = now - change_stamp[k];
    if (since >= {16'd0, debounce_ms} && level_stable[k] != raw_last[k]) begin
      level_stable[k] = raw_last[k];
      if (!level_stable[k]) begin
        held[k]        = 1'b1;
        long_done[k]   = 1'b0;
        press_stamp[k] = now;
      end else begin
        held[k] = 1'b0;
        if (!long_done[k]) is_short = 1'b1;
      end
    end
    since = now - press_stamp[k];
    if (held[k] && !long_done[k] && since >= {16'd0, long_ms}) begin
      long_done[k] = 1'b1;
      is_long      = 1'b1;
    end
  endfunction

  function void note_scan(logic [31:0] now, logic key0, logic key1);
    bit short0, long0, short1, long1;
    dkd_pkg::event_code_t code;
    step_key(1, now, key1, short1, long1);
    step_key(0, now, key0, short0, long0);
    if (long0)       code = dkd_pkg::EV_KEY0_LONG;
    else if (long1)  code = dkd_pkg::EV_KEY1_LONG;
    else if (short0) code = dkd_pkg::EV_KEY0_SHORT;
    else if (short1) code = dkd_pkg::EV_KEY1_SHORT;
    else             code = dkd_pkg::EV_NONE;
    expected_events.push_back(code);
  endfunction

  function int pending_count();
    return expected_events.size();
  endfunction

  task log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 50) $display("mismatch %0d: %s", mismatches, msg);
  endtask

  task check_event(logic [7:0] word);
    dkd_pkg::event_code_t want;
    dkd_pkg::event_code_t got;
    got = dkd_pkg::event_code_t'(word[dkd_pkg::EVENT_W-1:0]);
    if (expected_events.size() == 0) begin
      log_mismatch($sformatf("event code %0d with no scan outstanding", got));
    end else begin
      want = expected_events.pop_front();
      events_checked++;
      event_tally[want]++;
      if (got !== want)
        log_mismatch($sformatf("event code %0d, want %s", got, want.name()));
    end
  endtask
endclass

module dual_key_debounce_long_press_unit_tb;
  import dkd_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = REG_DEBOUNCE_TIME;
  logic [TIME_W-1:0]      cfg_data = '0;

  key_event_board sb;
  bit hold_off_req = 1'b0;
  int scans_sent = 0;
  int settings_run = 1;
  int quiet_cycles = 0;

  dual_key_debounce_long_press_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_event(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int mode;
    int stretch;
    int tick;
    stretch = 0;
    mode = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 2);
          stretch = $urandom_range(4, 64);
          tick = 0;
        end
        stretch--;
        tick++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (tick % 4) != 0;
        endcase
      end
    end
  end

  task automatic push_scan(input logic [31:0] now, input logic key0, input logic key1);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, key1, key0, now};
    do @(posedge clk); while (!s_tready);
    sb.note_scan(now, key0, key1);
    scans_sent++;
  endtask

  task automatic pause(input int cycles);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [TIME_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic configure(input logic [TIME_W-1:0] db, input logic [TIME_W-1:0] lp);
    pause(1);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(REG_DEBOUNCE_TIME, db);
    write_reg(REG_LONG_PRESS_TIME, lp);
    settings_run++;
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] db, input logic [TIME_W-1:0] lp,
                           input int count, input bit hold_mid);
    logic [31:0] now;
    logic lvl0, lvl1, send0, send1;
    int burst;
    int unsigned span;
    int pick;
    configure(db, lp);
    now = $urandom;
    lvl0 = 1'b1;
    lvl1 = 1'b1;
    burst = $urandom_range(1, 60);
    for (int i = 0; i < count; i++) begin
      if (hold_mid && i == count / 2) hold_off_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40)      span = 2;
      else if (pick < 75) span = db + 2;
      else if (pick < 95) span = lp + db + 2;
      else                span = 2 * lp + 2 * db + 10;
      if ($urandom_range(0, 99) < 3) now = $urandom;
      else                           now = now + $urandom_range(0, span);
      if ($urandom_range(0, 9) == 0) lvl0 = ~lvl0;
      if ($urandom_range(0, 9) == 0) lvl1 = ~lvl1;
      if ($urandom_range(0, 29) == 0) begin
        lvl0 = 1'b0;
        lvl1 = 1'b0;
      end
      send0 = lvl0 ^ ($urandom_range(0, 19) == 0);
      send1 = lvl1 ^ ($urandom_range(0, 19) == 0);
      push_scan(now, send0, send1);
      burst--;
      if (burst == 0) begin
        pause($urandom_range(1, 6));
        burst = $urandom_range(1, 60);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset thresholds: debounce, bounce, short, long, suppressed short, ties, wrap
    push_scan(32'd0,    1'b1, 1'b1);
    push_scan(32'd10,   1'b0, 1'b1);
    push_scan(32'd40,   1'b0, 1'b1);
    push_scan(32'd60,   1'b1, 1'b1);
    push_scan(32'd95,   1'b1, 1'b1);
    push_scan(32'd100,  1'b1, 1'b0);
    push_scan(32'd130,  1'b1, 1'b0);
    push_scan(32'd630,  1'b1, 1'b0);
    push_scan(32'd700,  1'b1, 1'b1);
    push_scan(32'd730,  1'b1, 1'b1);
    push_scan(32'd800,  1'b0, 1'b0);
    push_scan(32'd830,  1'b0, 1'b0);
    push_scan(32'd1330, 1'b0, 1'b0);
    push_scan(32'd1331, 1'b0, 1'b0);
    push_scan(32'd1400, 1'b1, 1'b1);
    push_scan(32'd1430, 1'b1, 1'b1);
    push_scan(32'd1500, 1'b0, 1'b0);
    push_scan(32'd1530, 1'b0, 1'b0);
    push_scan(32'd1600, 1'b1, 1'b1);
    push_scan(32'd1630, 1'b1, 1'b1);
    push_scan(32'd1700, 1'b0, 1'b1);
    push_scan(32'd1710, 1'b1, 1'b1);
    push_scan(32'd1740, 1'b1, 1'b1);
    push_scan(32'hFFFF_FFF0, 1'b0, 1'b1);
    push_scan(32'hFFFF_FFFF, 1'b0, 1'b1);
    push_scan(32'h0000_0010, 1'b0, 1'b1);

    // zero thresholds: stable and long in the press scan
    configure(16'd0, 16'd0);
    push_scan(32'd100, 1'b0, 1'b1);
    push_scan(32'd100, 1'b1, 1'b1);
    push_scan(32'd101, 1'b0, 1'b0);
    push_scan(32'd101, 1'b0, 1'b0);
    push_scan(32'd102, 1'b1, 1'b0);

    run_phase(16'd0,     16'd0,     240, 1'b0);
    run_phase(16'hFFFF,  16'hFFFF,  240, 1'b0);
    run_phase(16'd30,    16'd500,   240, 1'b1);
    run_phase(16'd0,     16'hFFFF,  240, 1'b0);
    run_phase(16'hFFFF,  16'd0,     240, 1'b0);
    run_phase(16'd1,     16'd1,     240, 1'b0);
    run_phase(16'($urandom_range(1, 60)), 16'($urandom_range(20, 600)), 240, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 240, 1'b0);

    pause(1);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Scanned %0d key samples under %0d threshold settings, %0d event codes checked.",
             scans_sent, settings_run, sb.events_checked);
    $display("Expected events: none %0d, key0 short %0d, key1 short %0d, key0 long %0d, key1 long %0d.",
             sb.event_tally[EV_NONE], sb.event_tally[EV_KEY0_SHORT],
             sb.event_tally[EV_KEY1_SHORT], sb.event_tally[EV_KEY0_LONG],
             sb.event_tally[EV_KEY1_LONG]);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire
